// ===== hdl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg - shared types and constants for the boundary tag allocator
// Result codes, stream widths, controller states, the datapath command enum
// and the status struct passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int ARENA_UNITS_DEF  = 1024;
    localparam int HEADER_UNITS_DEF = 4;

    localparam int SIZE_W     = 10;   // request_size, free_offset, block_offset
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_LOOP,
        S_A_CHK,
        S_F_LOOP,
        S_F_STEP,
        S_F_GOTQ,
        S_F_NX,
        S_F_FIN,
        S_POST
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_READ_P,
        DP_STEP,
        DP_TAKE,
        DP_CARVE,
        DP_FAIL_NOSPACE,
        DP_FAIL_BAD,
        DP_FREE_SET,
        DP_READ_NX,
        DP_FREE_FIN,
        DP_FREE_FIN_NONX,
        DP_POST
    } dp_cmd_t;

    typedef struct packed {
        logic mode_free;
        logic sz_zero;
        logic bad_off;
        logic p_end;
        logic p_at_q;
        logic hit;
        logic carve_ok;
        logic h_taken;
        logic nx_in;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/bta_dp.sv =====
// ----------------------------------------------------------------------------
// bta_dp - allocator datapath
// Header memory, head-of-arena header register, walk pointers, header
// arithmetic and the result output register.
// ----------------------------------------------------------------------------
module bta_dp #(
    parameter int ARENA_UNITS  = bta_pkg::ARENA_UNITS_DEF,
    parameter int HEADER_UNITS = bta_pkg::HEADER_UNITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bta_pkg::dp_cmd_t              cmd,
    output bta_pkg::dp_status_t           st,
    input  logic                          in_mode,
    input  logic [bta_pkg::SIZE_W-1:0]    in_request_size,
    input  logic [bta_pkg::SIZE_W-1:0]    in_free_offset,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bta_pkg::STATUS_W-1:0]  out_status,
    output logic [bta_pkg::SIZE_W-1:0]    out_block_offset
);
    import bta_pkg::*;

    localparam int AW = (ARENA_UNITS > 1) ? $clog2(ARENA_UNITS) : 1;
    // header word: signed length, wide enough for any offset sum in the arena
    localparam int W  = (AW + 2 > 12) ? AW + 2 : 12;
    localparam logic [W-1:0] HDR = W'(HEADER_UNITS);
    localparam logic [W-1:0] ARN = W'(ARENA_UNITS);

    logic [W-1:0] mem [ARENA_UNITS];

    logic                 mode_reg;
    logic                 bad_off_reg;
    logic [W-1:0]         sz_reg;
    logic [W-1:0]         q_reg;
    logic [W-1:0]         p_reg;
    logic [W-1:0]         pr_reg;
    logic                 pr_ok_reg;
    logic [W-1:0]         prh_reg;
    logic [W-1:0]         cur_reg;
    logic [W-1:0]         head_reg;
    logic [W-1:0]         rd_q_reg;
    logic                 rd_head_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [SIZE_W-1:0]    res_off_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [SIZE_W-1:0]    m_off_reg;

    logic [W-1:0] h;
    logic [W-1:0] h_abs;
    logic [W-1:0] next_p;
    logic [W-1:0] need;
    logic [W-1:0] rest;
    logic [W-1:0] hp;
    logic [W-1:0] neg_sz;
    logic [W-1:0] merged;
    logic         pr_merge;
    logic [W-1:0] nx;
    logic [W-1:0] fin;
    logic [W-1:0] off_w;
    logic [W-1:0] off_q;
    logic [W-1:0] p_pay;
    logic [W-1:0] hp_pay;

    logic         rd_en;
    logic [W-1:0] rd_addr;
    logic         wr_en;
    logic [W-1:0] wr_addr;
    logic [W-1:0] wr_data;

    // header 0 lives in a register so that reset defines it
    assign h       = rd_head_reg ? head_reg : rd_q_reg;
    assign h_abs   = h[W-1] ? (~h + W'(1)) : h;
    assign next_p  = p_reg + h_abs + HDR;
    assign need    = sz_reg + HDR;
    assign rest    = head_reg - need;
    assign hp      = rest + HDR;
    assign neg_sz  = ~sz_reg + W'(1);
    assign merged  = prh_reg + h_abs + HDR;
    assign pr_merge = pr_ok_reg && !prh_reg[W-1] && (prh_reg != '0);
    assign nx      = p_reg + cur_reg + HDR;
    assign fin     = cur_reg + h + HDR;
    assign off_w   = W'(in_free_offset);
    assign off_q   = off_w - HDR;
    assign p_pay   = p_reg + HDR;
    assign hp_pay  = hp + HDR;

    always_comb begin
        st.mode_free = (mode_reg == MODE_FREE);
        st.sz_zero   = (sz_reg == '0);
        st.bad_off   = bad_off_reg;
        st.p_end     = (p_reg >= ARN);
        st.p_at_q    = (p_reg == q_reg);
        st.hit       = !h[W-1] && (h == sz_reg);
        st.carve_ok  = !head_reg[W-1] && (need <= head_reg) && (hp < ARN);
        st.h_taken   = h[W-1];
        st.nx_in     = (nx < ARN);
        st.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        rd_en   = (cmd == DP_READ_P) || (cmd == DP_READ_NX);
        rd_addr = (cmd == DP_READ_NX) ? nx : p_reg;
        wr_en   = 1'b0;
        wr_addr = (cmd == DP_CARVE) ? hp : p_reg;
        wr_data = neg_sz;
        unique case (cmd)
            DP_TAKE, DP_CARVE: begin
                wr_en   = 1'b1;
                wr_data = neg_sz;
            end
            DP_FREE_FIN: begin
                wr_en   = 1'b1;
                wr_data = (!h[W-1] && h != '0) ? fin : cur_reg;
            end
            DP_FREE_FIN_NONX: begin
                wr_en   = 1'b1;
                wr_data = cur_reg;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    // header memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr != '0) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr[AW-1:0]];
            rd_head_reg <= (rd_addr == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= ARN - HDR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == DP_CARVE) begin
                head_reg <= rest;
            end else if (wr_en && wr_addr == '0) begin
                head_reg <= wr_data;
            end
            if (cmd == DP_POST) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd)
            DP_LOAD: begin
                mode_reg    <= in_mode;
                sz_reg      <= W'(in_request_size);
                q_reg       <= off_q;
                bad_off_reg <= (off_w < HDR) || (off_q >= ARN);
                p_reg       <= '0;
                pr_ok_reg   <= 1'b0;
            end
            DP_STEP: begin
                pr_reg    <= p_reg;
                prh_reg   <= h;
                pr_ok_reg <= 1'b1;
                p_reg     <= next_p;
            end
            DP_TAKE: begin
                res_status_reg <= ST_DONE;
                res_off_reg    <= p_pay[SIZE_W-1:0];
            end
            DP_CARVE: begin
                res_status_reg <= ST_DONE;
                res_off_reg    <= hp_pay[SIZE_W-1:0];
            end
            DP_FAIL_NOSPACE: begin
                res_status_reg <= ST_NOSPACE;
                res_off_reg    <= '0;
            end
            DP_FAIL_BAD: begin
                res_status_reg <= ST_BADFREE;
                res_off_reg    <= '0;
            end
            DP_FREE_SET: begin
                // fold into a free predecessor of nonzero length, else the block stands alone
                if (pr_merge) begin
                    p_reg   <= pr_reg;
                    cur_reg <= merged;
                end else begin
                    cur_reg <= h_abs;
                end
            end
            DP_FREE_FIN, DP_FREE_FIN_NONX: begin
                res_status_reg <= ST_DONE;
                res_off_reg    <= '0;
            end
            DP_POST: begin
                m_status_reg <= res_status_reg;
                m_off_reg    <= res_off_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid         = m_valid_reg;
    assign out_status       = m_status_reg;
    assign out_block_offset = m_off_reg;

endmodule

// ===== hdl/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl - allocator controller
// Sequences the header walk, the allocate and free decisions and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module bta_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bta_pkg::dp_status_t  st,
    output bta_pkg::dp_cmd_t     cmd
);
    import bta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = DP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // input side stays closed while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd        = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (st.mode_free) begin
                    if (st.bad_off) begin
                        cmd        = DP_FAIL_BAD;
                        state_next = S_POST;
                    end else begin
                        state_next = S_F_LOOP;
                    end
                end else if (st.sz_zero) begin
                    cmd        = DP_FAIL_NOSPACE;
                    state_next = S_POST;
                end else begin
                    state_next = S_A_LOOP;
                end
            end
            S_A_LOOP: begin
                if (st.p_end) begin
                    // no exact fit: carve from the tail of the first block, or report no space
                    cmd        = st.carve_ok ? DP_CARVE : DP_FAIL_NOSPACE;
                    state_next = S_POST;
                end else begin
                    cmd        = DP_READ_P;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (st.hit) begin
                    cmd        = DP_TAKE;
                    state_next = S_POST;
                end else begin
                    cmd        = DP_STEP;
                    state_next = S_A_LOOP;
                end
            end
            S_F_LOOP: begin
                priority if (st.p_at_q) begin
                    cmd        = DP_READ_P;
                    state_next = S_F_GOTQ;
                end else if (st.p_end) begin
                    cmd        = DP_FAIL_BAD;
                    state_next = S_POST;
                end else begin
                    cmd        = DP_READ_P;
                    state_next = S_F_STEP;
                end
            end
            S_F_STEP: begin
                cmd        = DP_STEP;
                state_next = S_F_LOOP;
            end
            S_F_GOTQ: begin
                if (!st.h_taken) begin
                    cmd        = DP_FAIL_BAD;
                    state_next = S_POST;
                end else begin
                    cmd        = DP_FREE_SET;
                    state_next = S_F_NX;
                end
            end
            S_F_NX: begin
                if (st.nx_in) begin
                    cmd        = DP_READ_NX;
                    state_next = S_F_FIN;
                end else begin
                    cmd        = DP_FREE_FIN_NONX;
                    state_next = S_POST;
                end
            end
            S_F_FIN: begin
                cmd        = DP_FREE_FIN;
                state_next = S_POST;
            end
            S_POST: begin
                if (st.out_free) begin
                    cmd        = DP_POST;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/boundary_tag_allocator.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_allocator - boundary tag heap allocator, exact fit first
//
//   channel  dir  tdata                               tuser
//   s_       in   [9:0] request_size [19:10] free_off [0] mode (0 alloc, 1 free)
//   m_       out  [9:0] block_offset                  [1:0] status
//
// One transaction at a time. Allocate walks the headers for an exact fit and
// carves from the first block if none is found (up to ARENA_UNITS /
// HEADER_UNITS blocks). Free walks the headers ahead of the target; a zero
// request or an offset rejected up front skips the walk. A header walked gets
// a read and a check state, with registered read data from the header memory.
// Reset is synchronous; header 0 is a register, so no clearing pass is needed.
// A new transaction is taken while a result waits on m_; a stalled m_ side
// holds the next result in the datapath until the output register frees.
// ----------------------------------------------------------------------------
module boundary_tag_allocator #(
    parameter int ARENA_UNITS  = bta_pkg::ARENA_UNITS_DEF,
    parameter int HEADER_UNITS = bta_pkg::HEADER_UNITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bta_pkg::S_TDATA_W-1:0]   s_tdata,  // request_size, free_offset
    input  logic [0:0]                      s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bta_pkg::M_TDATA_W-1:0]   m_tdata,  // block_offset
    output logic [bta_pkg::STATUS_W-1:0]    m_tuser   // status
);
    import bta_pkg::*;

    dp_cmd_t              cmd;
    dp_status_t           st;
    logic [STATUS_W-1:0]  out_status;
    logic [SIZE_W-1:0]    out_off;

    bta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bta_dp #(
        .ARENA_UNITS  (ARENA_UNITS),
        .HEADER_UNITS (HEADER_UNITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .in_mode          (s_tuser[0]),
        .in_request_size  (s_tdata[SIZE_W-1:0]),
        .in_free_offset   (s_tdata[2*SIZE_W-1:SIZE_W]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_status       (out_status),
        .out_block_offset (out_off)
    );

    assign m_tdata = M_TDATA_W'(out_off);
    assign m_tuser = out_status;

`ifndef NO_ASSERTIONS
    // one transaction in flight: the input side closes after each accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_NOSPACE ||
                      m_tuser == ST_BADFREE))
        else $error("undefined status code");

    a_fail_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata == '0))
        else $error("failed transaction carries a block offset");

    // a waiting result holds still until it is taken
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - boundary tag allocator stream test
// Drives allocate and free commands on the s_ channel and checks each result
// on m_ against a behavioral model of the arena's header chain. A directed
// opening covers the corner cases; a random phase then mixes well-formed
// alloc/free traffic with bad frees. The run ends by draining the heap and
// leaving a zero-length first block.
// ----------------------------------------------------------------------------
module testbench;
    import bta_pkg::*;

    localparam int ARENA = ARENA_UNITS_DEF;
    localparam int HDR   = HEADER_UNITS_DEF;
    localparam int RANDOM_CMDS = 680;

    typedef struct {
        logic                mode;
        logic [SIZE_W-1:0]   req_size;
        logic [SIZE_W-1:0]   free_off;
    } heap_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   offset;
    } heap_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} rx_pat_t;

    class heap_scoreboard;
        int           arena[ARENA];
        heap_result_t due_results[$];
        int           errors;

        function new();
            foreach (arena[i]) arena[i] = 0;
            arena[0] = ARENA - HDR;
            errors = 0;
        endfunction

        function int blk_len(int h);
            return (h < 0) ? -h : h;
        endfunction

        function heap_result_t allocate(int sz);
            heap_result_t r;
            int p, h, rest, hp;
            r.status = ST_NOSPACE;
            r.offset = '0;
            if (sz == 0) return r;
            p = 0;
            // exact fit: a free block whose length matches (sz > 0, so h >= 0)
            while (p < ARENA) begin
                h = arena[p];
                if (h == sz) begin
                    arena[p] = -h;
                    r.status = ST_DONE;
                    r.offset = SIZE_W'(p + HDR);
                    return r;
                end
                p += blk_len(h) + HDR;
            end
            // otherwise carve from the tail of the first block
            if (arena[0] < 0 || sz + HDR > arena[0]) return r;
            rest = arena[0] - sz - HDR;
            arena[0] = rest;
            hp = rest + HDR;
            if (hp >= ARENA) return r;
            arena[hp] = -sz;
            r.status = ST_DONE;
            r.offset = SIZE_W'(hp + HDR);
            return r;
        endfunction

        function heap_result_t release_block(int off);
            heap_result_t r;
            int q, p, pr, len, nx;
            r.status = ST_BADFREE;
            r.offset = '0;
            q = off - HDR;
            if (q < 0) return r;
            p = 0;
            pr = -1;
            while (p < ARENA && p != q) begin
                pr = p;
                p += blk_len(arena[p]) + HDR;
            end
            if (p != q || arena[q] >= 0) return r;
            len = -arena[q];
            arena[q] = len;
            p = q;
            // zero-length neighbors are never merged
            if (pr >= 0 && arena[pr] > 0) begin
                arena[pr] += len + HDR;
                p = pr;
            end
            nx = p + arena[p] + HDR;
            if (nx < ARENA && arena[nx] > 0) arena[p] += arena[nx] + HDR;
            r.status = ST_DONE;
            return r;
        endfunction

        function heap_result_t note(heap_cmd_t c);
            heap_result_t r;
            if (c.mode == MODE_FREE) r = release_block(int'(c.free_off));
            else r = allocate(int'(c.req_size));
            due_results.push_back(r);
            return r;
        endfunction

        task report(input string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check(input logic [STATUS_W-1:0] st, input logic [SIZE_W-1:0] off);
            heap_result_t e;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result status %0d offset %0d", st, off));
                return;
            end
            e = due_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (off !== e.offset)
                report($sformatf("block_offset %0d, expected %0d", off, e.offset));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [9:0] request_size, [19:10] free_offset
    logic [0:0]           s_tuser = '0;   // [0] mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [9:0] block_offset
    logic [STATUS_W-1:0]  m_tuser;        // [1:0] status

    heap_scoreboard heap_sb = new();

    int      n_accepted = 0;
    int      burst_left = 0;
    int      live_off[$];
    int      live_size[$];
    int      freed_off[$];
    int      freed_size[$];
    logic    rx_hold = 1'b0;
    rx_pat_t rx_pattern = RX_OPEN;
    int      rx_phase_left = 0;

    boundary_tag_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            heap_sb.check(m_tuser, m_tdata[SIZE_W-1:0]);
    end

    // receiver: picks a new random stall pattern whenever its phase counter runs out
    always @(negedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_pattern    <= rx_pat_t'($urandom_range(3));
            rx_phase_left <= $urandom_range(40, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_pattern)
                RX_OPEN:  m_tready <= 1'b1;
                RX_HALF:  m_tready <= ($urandom_range(1) == 1);
                RX_LIGHT: m_tready <= ($urandom_range(3) != 0);
                default:  m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // long back-pressure window so the block fills and stalls s_
    initial begin
        wait (n_accepted >= 150);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("[boundary_tag_allocator] ERROR");
        $finish;
    end

    task automatic send_cmd(input heap_cmd_t c, output heap_result_t r);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({c.free_off, c.req_size});
        s_tuser  <= c.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = heap_sb.note(c);
        n_accepted++;
    endtask

    task automatic issue(input heap_cmd_t c);
        heap_result_t r;
        int idx, gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        send_cmd(c, r);
        if (r.status == ST_DONE) begin
            if (c.mode == MODE_ALLOC) begin
                live_off.push_back(int'(r.offset));
                live_size.push_back(int'(c.req_size));
            end else begin
                idx = -1;
                foreach (live_off[i]) if (live_off[i] == int'(c.free_off)) idx = i;
                if (idx >= 0) begin
                    freed_off.push_back(live_off[idx]);
                    freed_size.push_back(live_size[idx]);
                    live_off.delete(idx);
                    live_size.delete(idx);
                    if (freed_off.size() > 16) begin
                        void'(freed_off.pop_front());
                        void'(freed_size.pop_front());
                    end
                end
            end
        end
    endtask

    task automatic issue_alloc(input int sz);
        heap_cmd_t c;
        c.mode     = MODE_ALLOC;
        c.req_size = SIZE_W'(sz);
        c.free_off = SIZE_W'($urandom);
        issue(c);
    endtask

    task automatic issue_free(input int off);
        heap_cmd_t c;
        c.mode     = MODE_FREE;
        c.req_size = SIZE_W'($urandom);
        c.free_off = SIZE_W'(off);
        issue(c);
    endtask

    task automatic pick_random(output heap_cmd_t c);
        int roll, k, sz, alloc_pct;
        c.mode     = MODE_ALLOC;
        c.req_size = SIZE_W'($urandom);
        c.free_off = SIZE_W'($urandom);
        alloc_pct  = (live_off.size() > 20) ? 25 : 50;
        roll       = $urandom_range(99);
        if (roll < alloc_pct || (roll < 88 && live_off.size() == 0)) begin
            k = $urandom_range(9);
            if (k < 3 && freed_size.size() > 0)
                sz = freed_size[$urandom_range(freed_size.size() - 1)];
            else if (k == 3)
                sz = ($urandom_range(1) == 0) ? 0 : $urandom_range(300, 1023);
            else
                sz = $urandom_range(1, 64);
            // keep the first block from shrinking to zero length before the end
            if (sz + HDR == heap_sb.arena[0]) sz++;
            c.req_size = SIZE_W'(sz);
        end else if (roll < 88) begin
            c.mode     = MODE_FREE;
            c.free_off = SIZE_W'(live_off[$urandom_range(live_off.size() - 1)]);
        end else begin
            c.mode = MODE_FREE;
            k = $urandom_range(3);
            case (k)
                0: c.free_off = SIZE_W'($urandom_range(HDR - 1));
                1: ;
                2: if (freed_off.size() > 0)
                       c.free_off = SIZE_W'(freed_off[$urandom_range(freed_off.size() - 1)]);
                default: if (live_off.size() > 0)
                       c.free_off = SIZE_W'(live_off[$urandom_range(live_off.size() - 1)]
                                            + $urandom_range(1, 3));
            endcase
        end
    endtask

    initial begin
        heap_cmd_t c;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        issue_alloc(0);
        issue_alloc(1023);
        issue_free(0);
        issue_free(HDR - 1);
        issue_free(1023);
        issue_alloc(ARENA - HDR);       // exact fit of the whole arena
        issue_alloc(1);                 // first block taken
        issue_free(HDR);                // first block freed, nothing after it
        issue_alloc(500);
        issue_alloc(516);               // exact fit at the first block
        issue_free(524);
        issue_free(HDR);                // first block freed, merges its successor
        issue_alloc(1);
        issue_alloc(1016);              // too big for the first block
        issue_free(1023);
        issue_free(1023);               // double free
        issue_free(512);                // not on the chain

        repeat (RANDOM_CMDS) begin
            pick_random(c);
            issue(c);
        end

        while (live_off.size() > 0) issue_free(live_off[0]);

        // leave a zero-length free block at offset 0
        issue_alloc(heap_sb.arena[0] - HDR);
        issue_alloc(5);
        if (live_off.size() > 0) issue_free(live_off[live_off.size() - 1]);
        if (freed_size.size() > 0) issue_alloc(freed_size[freed_size.size() - 1]);
        if (live_off.size() > 0) issue_free(live_off[0]);
        issue_alloc(200);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (heap_sb.due_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (heap_sb.errors == 0) begin
            $display("[boundary_tag_allocator] OK");
        end else begin
            $display("[boundary_tag_allocator] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bta_pkg.sv
hdl/bta_dp.sv
hdl/bta_ctrl.sv
hdl/boundary_tag_allocator.sv
tb/testbench.sv
